// ===== hw/rtl/cfs_pkg.sv =====
// Package for the CAN frame serializer: request and chunk payload types,
// frame layout constants and the sequencer state type. No dependencies.
package cfs_pkg;

	localparam int MaxDataBytes = 8;
	localparam int HdrExtBits   = 39;
	localparam int HdrStdBits   = 19;
	localparam int CrcBits      = 15;
	localparam int TailBits     = 10;
	localparam int RunLimit     = 5;

	localparam logic [14:0] CrcPoly = 15'h4599;

	typedef struct packed {
		logic [10:0] base_id;
		logic [17:0] ext_id;
		logic        extended;
		logic        remote;
		logic [3:0]  dlc;
		logic [63:0] payload;
	} req_t;

	typedef struct packed {
		logic [7:0]  chunk;
		logic [3:0]  chunk_bits;
		logic        last;
		logic [14:0] crc_value;
		logic [7:0]  total_bits;
	} rsp_t;

	// one wire bit handed from the sequencer to the packer
	typedef struct packed {
		logic push;
		logic value;
		logic final_bit;
	} wire_bit_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_DATA,
		PH_CRC,
		PH_TAIL
	} phase_t;

endpackage

// ===== hw/rtl/cfs_packer.sv =====
// Packs the serial wire bits of a frame into left-aligned 8-bit chunks
// and holds each chunk in the output register. Depends on cfs_pkg.
module cfs_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  cfs_pkg::wire_bit_t wbit,
	input  logic [14:0]       crc,
	output logic              ready,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output cfs_pkg::rsp_t     rsp
);
	import cfs_pkg::*;

	logic [7:0] buf_q;
	logic [2:0] nb_q;
	logic [7:0] tot_q;
	logic       valid_q;
	rsp_t       rsp_q;
	logic [7:0] buf_d;
	logic       emit;

	assign ready     = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		buf_d        = buf_q;
		buf_d[~nb_q] = wbit.value;
	end

	assign emit = wbit.push && ((nb_q == 3'd7) || wbit.final_bit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= '0;
			nb_q    <= '0;
			tot_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (wbit.push) begin
				if (emit) begin
					buf_q <= '0;
					nb_q  <= '0;
				end else begin
					buf_q <= buf_d;
					nb_q  <= nb_q + 3'd1;
				end
				tot_q <= wbit.final_bit ? 8'd0 : tot_q + 8'd1;
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.chunk      <= buf_d;
			rsp_q.chunk_bits <= {1'b0, nb_q} + 4'd1;
			rsp_q.last       <= wbit.final_bit;
			rsp_q.crc_value  <= wbit.final_bit ? crc : 15'd0;
			rsp_q.total_bits <= wbit.final_bit ? tot_q + 8'd1 : 8'd0;
		end
	end

endmodule

// ===== hw/rtl/can_frame_serializer.sv =====
// Top level of the CAN 2.0 frame serializer: bit sequencer, CRC-15 and
// bit stuffing. Depends on cfs_pkg and cfs_packer.
//
// Usage:
//   req channel (req_valid, req_stall, req) takes one message request:
//   identifiers, format flags, dlc and up to eight payload bytes.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns the stuffed wire bits
//   of the frame in chunks of up to 8 bits, first bit in bit 7, with last,
//   crc_value and total_bits set on the final chunk.
// Timing:
//   One wire bit is produced per cycle, stuff bits included, while the
//   output is not stalled; a frame holds 44 to 157 stuffed bits. Each chunk
//   is registered and appears in the cycle after its last bit. The next
//   request is taken in the cycle after the final EOF bit, and none is
//   taken while a frame is in progress; the sequencer sets the rate.
// Reset and stall:
//   Reset empties the sequencer and the output register; req_stall is high
//   while a frame is in progress. While a chunk is held by rsp_stall the
//   sequencer freezes, so no bit is lost.
module can_frame_serializer (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  cfs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output cfs_pkg::rsp_t rsp
);
	import cfs_pkg::*;

	phase_t      state_q, state_d;
	logic [38:0] hdr_q;
	logic [63:0] pay_q;
	logic [5:0]  cnt_q;
	logic [5:0]  dcnt_q;
	logic        has_data_q;
	logic [14:0] crc_q;
	logic [2:0]  run_q;
	logic        prev_q;

	logic        accept;
	logic        adv;
	logic        stuff_now;
	logic        src_bit;
	logic        feed_crc;
	logic        field_end;
	logic        fb;
	logic [14:0] crc_d;
	logic [3:0]  nbytes;
	logic [6:0]  dbits;
	wire_bit_t   wbit;
	logic        pk_ready;

	assign req_stall = (state_q != PH_IDLE);
	assign accept    = req_valid && (state_q == PH_IDLE);
	assign adv       = pk_ready && (state_q != PH_IDLE);
	assign stuff_now = (run_q == 3'(RunLimit));
	assign field_end = (cnt_q == 6'd0) && !stuff_now;

	assign nbytes = (req.dlc > 4'(MaxDataBytes)) ? 4'(MaxDataBytes) : req.dlc;
	assign dbits  = {nbytes, 3'b000};

	assign fb    = src_bit ^ crc_q[14];
	assign crc_d = {crc_q[13:0], 1'b0} ^ (fb ? CrcPoly : 15'd0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_IDLE: begin
				if (accept) state_d = PH_HDR;
			end
			PH_HDR: begin
				if (adv && field_end) state_d = has_data_q ? PH_DATA : PH_CRC;
			end
			PH_DATA: begin
				if (adv && field_end) state_d = PH_CRC;
			end
			PH_CRC: begin
				if (adv && field_end) state_d = PH_TAIL;
			end
			PH_TAIL: begin
				if (adv && field_end) state_d = PH_IDLE;
			end
			default: state_d = PH_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		src_bit        = 1'b1;
		feed_crc       = 1'b0;
		wbit.push      = adv;
		wbit.final_bit = 1'b0;
		unique case (state_q)
			PH_IDLE: begin
				wbit.push = 1'b0;
			end
			PH_HDR: begin
				src_bit  = hdr_q[38];
				feed_crc = !stuff_now;
			end
			PH_DATA: begin
				src_bit  = pay_q[63];
				feed_crc = !stuff_now;
			end
			PH_CRC: begin
				src_bit = hdr_q[38];
			end
			PH_TAIL: begin
				src_bit        = 1'b1;
				wbit.final_bit = adv && field_end;
			end
			default: wbit.push = 1'b0;
		endcase
		wbit.value = stuff_now ? !prev_q : src_bit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			run_q   <= '0;
			prev_q  <= 1'b0;
			crc_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				run_q  <= '0;
				prev_q <= 1'b0;
				crc_q  <= '0;
			end else if (adv) begin
				if (stuff_now) begin
					run_q  <= 3'd1;
					prev_q <= !prev_q;
				end else if (state_q != PH_TAIL) begin
					run_q  <= (run_q != 3'd0 && src_bit == prev_q) ? run_q + 3'd1 : 3'd1;
					prev_q <= src_bit;
				end else if (field_end) begin
					run_q <= '0;
				end
				if (feed_crc) crc_q <= crc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.extended) begin
				hdr_q <= {1'b0, req.base_id, 1'b1, 1'b1, req.ext_id, req.remote,
					2'b00, req.dlc};
				cnt_q <= 6'(HdrExtBits - 1);
			end else begin
				hdr_q <= {1'b0, req.base_id, req.remote, 2'b00, req.dlc,
					20'd0};
				cnt_q <= 6'(HdrStdBits - 1);
			end
			pay_q      <= req.payload;
			dcnt_q     <= 6'(dbits - 7'd1);
			has_data_q <= !req.remote && (nbytes != 4'd0);
		end else if (adv && !stuff_now) begin
			cnt_q <= cnt_q - 6'd1;
			unique case (state_q)
				PH_HDR: begin
					hdr_q <= {hdr_q[37:0], 1'b0};
					if (field_end) begin
						if (has_data_q) begin
							cnt_q <= dcnt_q;
						end else begin
							hdr_q <= {crc_d, 24'd0};
							cnt_q <= 6'(CrcBits - 1);
						end
					end
				end
				PH_DATA: begin
					pay_q <= {pay_q[62:0], 1'b0};
					if (field_end) begin
						hdr_q <= {crc_d, 24'd0};
						cnt_q <= 6'(CrcBits - 1);
					end
				end
				PH_CRC: begin
					hdr_q <= {hdr_q[37:0], 1'b0};
					if (field_end) cnt_q <= 6'(TailBits - 1);
				end
				PH_TAIL: begin
				end
				default: begin
				end
			endcase
		end
	end

	cfs_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.wbit      (wbit),
		.crc       (crc_q),
		.ready     (pk_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run_q <= 3'(RunLimit))
		else $error("run length beyond stuffing limit");

	a_final_in_tail: assert property (@(posedge clk) disable iff (!arst_n)
		wbit.final_bit |-> (state_q == PH_TAIL) && wbit.push)
		else $error("final bit outside tail");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(!pk_ready && state_q != PH_IDLE) |=> $stable(state_q) && $stable(cnt_q))
		else $error("sequencer advanced while output held");

	a_last_total: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |-> (rsp.total_bits != 8'd0))
		else $error("last chunk without frame length");

endmodule
